[hw/rtl/psqc_pkg.sv]
`timescale 1ns / 1ps
package psqc_pkg;

  typedef enum logic [2:0] {
    TYPE_F32 = 3'd0,
    TYPE_U8  = 3'd1,
    TYPE_U16 = 3'd2,
    TYPE_S8  = 3'd3,
    TYPE_S16 = 3'd4
  } data_type_e;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  data_type;
    logic [5:0]  scale;
    logic [31:0] mem_data;
    logic [63:0] value_bits;
  } item_t;

  typedef struct packed {
    logic [63:0] double_bits;
    logic [31:0] store_bits;
    logic [2:0]  store_bytes;
    logic        bad_type;
  } result_t;

  // Position of the leading one of a 24-bit value (zero for zero).
  function automatic logic [4:0] lead_one(input logic [23:0] m);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

[hw/rtl/psqc_convert.sv]
`timescale 1ns / 1ps
module psqc_convert import psqc_pkg::*; (
  input  item_t   item_i,
  output result_t result_o
);

  logic        neg_int;
  logic [16:0] mag_in;
  logic [4:0]  lp_int;
  logic [23:0] fman;
  logic [4:0]  lp_f;
  logic [7:0]  fex;
  logic [63:0] dbl;
  logic [31:0] st;
  logic [2:0]  bytes;
  logic        bad;
  logic        is_int;
  logic [10:0] dexp;
  logic        dneg;
  logic signed [12:0] e;
  logic [16:0] mag;
  logic [52:0] full;
  logic        sat_hi;
  logic        sat_lo;
  logic signed [17:0] lo;
  logic signed [17:0] hi;
  logic signed [17:0] v;
  logic signed [17:0] q;
  logic signed [11:0] ex_int;
  logic [15:0] md16;
  logic [7:0]  md8;

  always_comb begin
    md16 = item_i.mem_data[15:0];
    md8  = item_i.mem_data[7:0];
    bad = 1'b0;
    is_int = 1'b1;
    bytes = 3'd4;
    neg_int = 1'b0;
    mag_in = '0;
    lo = '0;
    hi = '0;
    case (item_i.data_type)
      TYPE_F32: begin
        is_int = 1'b0;
      end
      TYPE_U8: begin
        bytes = 3'd1; mag_in = {9'd0, md8}; hi = 18'sd255;
      end
      TYPE_U16: begin
        bytes = 3'd2; mag_in = {1'b0, md16}; hi = 18'sd65535;
      end
      TYPE_S8: begin
        bytes = 3'd1; neg_int = md8[7];
        mag_in = md8[7] ? {9'd0, 8'(-md8)} : {9'd0, md8};
        if (md8 == 8'h80) mag_in = 17'd128;
        lo = -18'sd128; hi = 18'sd127;
      end
      TYPE_S16: begin
        bytes = 3'd2; neg_int = md16[15];
        mag_in = md16[15] ? {1'b0, 16'(-md16)} : {1'b0, md16};
        if (md16 == 16'h8000) mag_in = 17'd32768;
        lo = -18'sd32768; hi = 18'sd32767;
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    // Load path.
    lp_int = lead_one({7'd0, mag_in});
    ex_int = 12'sd1023 + 12'(lp_int) - 12'(signed'(item_i.scale));
    fex  = item_i.mem_data[30:23];
    fman = {1'b0, item_i.mem_data[22:0]};
    lp_f = lead_one(fman);
    dbl = '0;
    if (is_int) begin
      if (mag_in != '0) begin
        dbl = {neg_int, ex_int[10:0], 52'(({35'd0, mag_in} << (6'd52 - {1'b0, lp_int})))};
      end
    end else if (fex == 8'hFF) begin
      dbl = {item_i.mem_data[31], 11'h7FF, item_i.mem_data[22:0], 29'd0};
    end else if (fex == 8'd0) begin
      dbl = {item_i.mem_data[31], 63'd0};
      if (fman != '0) begin
        dbl = {item_i.mem_data[31], 11'(11'd874 + 11'(lp_f)),
               52'(({29'd0, fman[22:0]} << (6'd52 - {1'b0, lp_f})))};
      end
    end else begin
      dbl = {item_i.mem_data[31], 11'({3'd0, fex} + 11'd896), item_i.mem_data[22:0], 29'd0};
    end

    // Store path.
    dneg = item_i.value_bits[63];
    dexp = item_i.value_bits[62:52];
    e = 13'(dexp) - 13'sd1023 + 13'(signed'(item_i.scale));
    full = {1'b1, item_i.value_bits[51:0]};
    mag = '0;
    if (e >= 0 && e < 17) mag = 17'(full >> (6'd52 - 6'(e)));
    sat_hi = 1'b0;
    sat_lo = 1'b0;
    if (dexp == 11'h7FF || (dexp != 0 && e >= 17)) begin
      sat_lo = dneg; sat_hi = !dneg;
    end
    v = dneg ? -18'(signed'({1'b0, mag})) : 18'(signed'({1'b0, mag}));
    if (dexp == 0) v = '0;
    if (sat_lo) q = lo;
    else if (sat_hi) q = hi;
    else if (v < lo) q = lo;
    else if (v > hi) q = hi;
    else q = v;

    st = '0;
    if (!is_int) begin
      st = (dexp <= 11'd896) ? {dneg, 31'd0}
         : {item_i.value_bits[63:62], item_i.value_bits[58:29]};
    end else if (bytes == 3'd1) begin
      st = {24'd0, q[7:0]};
    end else begin
      st = {16'd0, q[15:0]};
    end

    result_o.bad_type    = bad;
    result_o.store_bytes = bytes;
    result_o.double_bits = (bad || item_i.cmd == CMD_STORE) ? '0 : dbl;
    result_o.store_bits  = (bad || item_i.cmd == CMD_LOAD) ? '0 : st;
  end

endmodule

[hw/rtl/paired_single_quantize_convert.sv]
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in       in_valid_i/ready_o   cmd, data_type, scale, mem_data, value_bits
// out      out_valid_o/ready_i  double_bits, store_bits, store_bytes, bad_type
// An item is registered, converted combinationally and held in the result register.
// One item per cycle is taken while the output is taken.
// The input register refills when the result register frees or is empty.
// Reset clears the valid bits only.
module paired_single_quantize_convert import psqc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [2:0]  data_type_i,
  input  logic [5:0]  scale_i,
  input  logic [31:0] mem_data_i,
  input  logic [63:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] double_bits_o,
  output logic [31:0] store_bits_o,
  output logic [2:0]  store_bytes_o,
  output logic        bad_type_o
);

  item_t   in_q;
  logic    in_vld_q;
  result_t res_d, res_q;
  logic    res_vld_q;
  logic    res_load;

  psqc_convert u_conv (.item_i(in_q), .result_o(res_d));

  assign res_load   = in_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || res_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (res_load) res_vld_q <= 1'b1;
      else if (out_ready_i) res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= '{cmd: cmd_i, data_type: data_type_i, scale: scale_i,
                mem_data: mem_data_i, value_bits: value_bits_i};
    end
    if (res_load) res_q <= res_d;
  end

  assign out_valid_o   = res_vld_q;
  assign double_bits_o = res_q.double_bits;
  assign store_bits_o  = res_q.store_bits;
  assign store_bytes_o = res_q.store_bytes;
  assign bad_type_o    = res_q.bad_type;

endmodule

[hw/rtl/psqc_checker.sv]
`timescale 1ns / 1ps
module psqc_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  store_bytes_o,
  input logic        bad_type_o
);

  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (store_bytes_o == 3'd1 || store_bytes_o == 3'd2 || store_bytes_o == 3'd4))
    else $error("bad store size");
  a_badsz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_type_o) |-> store_bytes_o == 3'd4)
    else $error("bad type size");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("stalled with free output");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped");

endmodule

bind paired_single_quantize_convert psqc_props u_chk (.*);

[tb/psqc_checker.sv]
`timescale 1ns / 1ps
module psqc_checker import psqc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        cmd_i,
  input  logic [2:0]  data_type_i,
  input  logic [5:0]  scale_i,
  input  logic [31:0] mem_data_i,
  input  logic [63:0] value_bits_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] double_bits_i,
  input  logic [31:0] store_bits_i,
  input  logic [2:0]  store_bytes_i,
  input  logic        bad_type_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o
);

  result_t expected_q[$];

  // Exact double of (-1)^neg * m * 2^pow2 for nonzero m with a normal result.
  function automatic logic [63:0] exact_double(input logic neg, input logic [63:0] m,
                                               input int pow2);
    int p;
    logic [63:0] frac;
    p = 0;
    for (int i = 0; i < 64; i++) if (m[i]) p = i;
    frac = (m << (52 - p)) & 64'h000F_FFFF_FFFF_FFFF;
    return {neg, 11'(1023 + p + pow2), frac[51:0]};
  endfunction

  function automatic logic [63:0] float_to_double(input logic [31:0] f);
    logic [7:0] ex;
    ex = f[30:23];
    if (ex == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'd0};
    if (ex == 8'd0) begin
      if (f[22:0] == 0) return {f[31], 63'd0};
      return exact_double(f[31], {41'd0, f[22:0]}, -149);
    end
    return {f[31], 11'(ex + 896), f[22:0], 29'd0};
  endfunction

  function automatic int saturate_quant(input logic [63:0] d, input int sc,
                                        input int lo, input int hi);
    int e;
    longint v;
    logic [63:0] mag;
    if (d[62:52] == 11'h7FF) return d[63] ? lo : hi;
    if (d[62:52] == 0) v = 0;
    else begin
      e = int'(d[62:52]) - 1023 + sc;
      if (e < 0) v = 0;
      else if (e >= 17) return d[63] ? lo : hi;
      else begin
        mag = {11'd0, 1'b1, d[51:0]} >> (52 - e);
        v = d[63] ? -longint'(mag) : longint'(mag);
      end
    end
    if (v < lo) return lo;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic result_t convert(input item_t it);
    result_t r;
    int sc;
    longint iv;
    logic [63:0] mag;
    int q;
    r = '0;
    r.store_bytes = 3'd4;
    sc = int'(it.scale);
    if (it.scale[5]) sc -= 64;
    iv = 0;
    case (it.data_type)
      TYPE_F32: ;
      TYPE_U8:  begin r.store_bytes = 3'd1; iv = longint'(it.mem_data[7:0]); end
      TYPE_U16: begin r.store_bytes = 3'd2; iv = longint'(it.mem_data[15:0]); end
      TYPE_S8:  begin r.store_bytes = 3'd1; iv = longint'($signed(it.mem_data[7:0])); end
      TYPE_S16: begin r.store_bytes = 3'd2; iv = longint'($signed(it.mem_data[15:0])); end
      default: r.bad_type = 1'b1;
    endcase
    if (r.bad_type) return r;
    if (it.cmd == CMD_LOAD) begin
      if (it.data_type == TYPE_F32) r.double_bits = float_to_double(it.mem_data);
      else if (iv != 0) begin
        mag = (iv < 0) ? 64'(-iv) : 64'(iv);
        r.double_bits = exact_double(iv < 0, mag, -sc);
      end
    end else begin
      case (it.data_type)
        TYPE_F32: begin
          if (it.value_bits[62:52] <= 11'd896) r.store_bits = {it.value_bits[63], 31'd0};
          else r.store_bits = {it.value_bits[63:62], it.value_bits[58:29]};
        end
        TYPE_U8:  r.store_bits = saturate_quant(it.value_bits, sc, 0, 'hFF);
        TYPE_U16: r.store_bits = saturate_quant(it.value_bits, sc, 0, 'hFFFF);
        TYPE_S8: begin
          q = saturate_quant(it.value_bits, sc, -'h80, 'h7F);
          r.store_bits = q & 'hFF;
        end
        default: begin
          q = saturate_quant(it.value_bits, sc, -'h8000, 'h7FFF);
          r.store_bits = q & 'hFFFF;
        end
      endcase
    end
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    results_seen_o = 0;
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    result_t want;
    item_t it;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result dbl=%h st=%h", $time, double_bits_i, store_bits_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.double_bits !== double_bits_i || want.store_bits !== store_bits_i ||
              want.store_bytes !== store_bytes_i || want.bad_type !== bad_type_i) begin
            $display("%0t: mismatch expected dbl=%h st=%h bytes=%0d bad=%b", $time,
                     want.double_bits, want.store_bits, want.store_bytes, want.bad_type);
            $display("%0t:          actual   dbl=%h st=%h bytes=%0d bad=%b", $time,
                     double_bits_i, store_bits_i, store_bytes_i, bad_type_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        it = '{cmd_i, data_type_i, scale_i, mem_data_i, value_bits_i};
        expected_q.push_back(convert(it));
      end
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb import psqc_pkg::*; ();

  localparam int StallLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = 1'b0;
  logic [2:0]  data_type_i = '0;
  logic [5:0]  scale_i = '0;
  logic [31:0] mem_data_i = '0;
  logic [63:0] value_bits_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] double_bits_o;
  logic [31:0] store_bits_o;
  logic [2:0]  store_bytes_o;
  logic        bad_type_o;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          idle_cycles = 0;
  int          items_sent = 0;
  bit          stim_done = 1'b0;

  always #2 clk_i = ~clk_i;

  paired_single_quantize_convert dut (.*);

  psqc_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .data_type_i,
    .scale_i, .mem_data_i, .value_bits_i, .out_valid_i(out_valid_o), .out_ready_i,
    .double_bits_i(double_bits_o), .store_bits_i(store_bits_o),
    .store_bytes_i(store_bytes_o), .bad_type_i(bad_type_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Doubles that land near the interesting edges of the conversions.
  function automatic logic [63:0] pick_double();
    logic [63:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: d[62:52] = 11'(1023 + $urandom_range(0, 40) - 20);
      1: d[62:52] = 11'(896 + $urandom_range(0, 4) - 2);
      2: d[62:52] = 11'h7FF;
      3: d[62:52] = ($urandom_range(0, 1) != 0) ? 11'd0 : 11'(1023 + 127 + $urandom_range(0, 3));
      default: ;
    endcase
    return d;
  endfunction

  // Valid stays high after an accepted item so that the next item can follow
  // back to back; it is dropped here at the start of a gap or before a pause.
  task automatic drop_valid();
    in_valid_i <= 1'b0;
  endtask

  task automatic send_item(input logic c, input logic [2:0] ty, input logic [5:0] sc,
                           input logic [31:0] md, input logic [63:0] vb);
    int g;
    g = gap_len();
    if (g > 0) begin
      drop_valid();
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c;
    data_type_i <= ty;
    scale_i <= sc;
    mem_data_i <= md;
    value_bits_i <= vb;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) < 70 || (stim_done && pending == 0)) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 9) == 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: every type both ways, scale extremes, float specials.
    for (int t = 0; t < 8; t++) begin
      send_item(CMD_LOAD, 3'(t), 6'h20, 32'hFFFF_FFFF, 64'd0);
      send_item(CMD_STORE, 3'(t), 6'h1F, 32'd0, 64'h7FF8_0000_0000_0001);
    end
    send_item(CMD_LOAD, TYPE_F32, 6'h00, 32'h7F80_0001, 64'd0);
    send_item(CMD_LOAD, TYPE_F32, 6'h00, 32'h8000_0001, 64'd0);
    send_item(CMD_LOAD, TYPE_U16, 6'h00, 32'd0, 64'd0);
    send_item(CMD_STORE, TYPE_F32, 6'h00, 32'd0, 64'hB800_0000_0000_0000);
    send_item(CMD_STORE, TYPE_F32, 6'h00, 32'd0, 64'hFFF0_0000_0000_0000);
    send_item(CMD_STORE, TYPE_S16, 6'h1F, 32'd0, 64'hFFF8_0000_0000_0000);
    send_item(CMD_STORE, TYPE_U8, 6'h00, 32'd0, 64'hBFF8_0000_0000_0000);
    send_item(CMD_STORE, TYPE_S8, 6'h20, 32'd0, 64'h7FF0_0000_0000_0000);
    // Hold off until the block has drained.
    drop_valid();
    wait (pending == 0);
    repeat (3) @(negedge clk_i);
    for (int n = 0; n < 1330; n++) begin
      send_item(1'($urandom_range(0, 1)), ($urandom_range(0, 9) == 0)
                ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)), 6'($urandom),
                $urandom, pick_double());
      if (n == 700) begin
        drop_valid();
        wait (pending == 0);
        @(negedge clk_i);
      end
    end
    drop_valid();
    stim_done = 1'b1;
    wait (pending == 0);
    repeat (10) @(negedge clk_i);
    $display("Sent %0d conversions (loads and stores, all data types, scale extremes,", items_sent);
    $display("float and NaN edge cases); %0d results checked.", results_seen);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
